// File: src/sts_pkg.sv
package sts_pkg;

    localparam int DATA_W  = 32;
    localparam int INDEX_W = 8;
    localparam int COUNT_W = 9;

    localparam logic ACTION_WRITE  = 1'b0;
    localparam logic ACTION_SEARCH = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CMP  = 2'b10
    } state_t;

    typedef struct packed {
        logic               done;
        logic               found;
        logic [INDEX_W-1:0] found_index;
    } result_t;

endpackage

// File: src/sts_ram.sv
module sts_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/sts_ctrl.sv
module sts_ctrl
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [DATA_W-1:0]  entry_value,
    input  logic [DATA_W-1:0]  search_key,
    input  logic [COUNT_W-1:0] entry_count,
    output logic               mem_we,
    output logic               mem_re,
    output logic [ADDR_W-1:0]  mem_addr,
    output logic [DATA_W-1:0]  mem_wdata,
    input  logic [DATA_W-1:0]  mem_rdata,
    output result_t            result
);

    localparam int CNT_W = ($clog2(TABLE_DEPTH + 1) > COUNT_W) ?
                           $clog2(TABLE_DEPTH + 1) : COUNT_W;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          low_reg, low_next;
    logic [CNT_W-1:0]          hi_reg, hi_next;
    logic [ADDR_W-1:0]         probe_reg, probe_next;
    logic signed [DATA_W-1:0]  key_reg, key_next;
    logic                      done_reg, done_next;
    logic                      found_reg, found_next;
    logic [INDEX_W-1:0]        found_index_reg, found_index_next;

    logic                      accept;
    logic [CNT_W-1:0]          count_w;
    logic [CNT_W-1:0]          n_sat;
    logic [CNT_W-1:0]          first_probe;
    logic                      wr_in_range;
    logic signed [DATA_W-1:0]  rd_value;
    logic                      eq;
    logic                      gt;
    logic [CNT_W-1:0]          cmp_low;
    logic [CNT_W-1:0]          cmp_hi;
    logic                      cmp_empty;
    logic [CNT_W:0]            cmp_sum;
    logic [ADDR_W-1:0]         cmp_probe;

    assign busy        = (state_reg != ST_IDLE);
    assign accept      = start && !busy;
    assign count_w     = CNT_W'(entry_count);
    assign n_sat       = (count_w > DEPTH_C) ? DEPTH_C : count_w;
    assign first_probe = (n_sat - CNT_W'(1)) >> 1;
    assign wr_in_range = (CNT_W'(entry_index) < DEPTH_C);

    assign rd_value  = $signed(mem_rdata);
    assign eq        = (rd_value == key_reg);
    assign gt        = (rd_value > key_reg);
    assign cmp_low   = gt ? low_reg : (CNT_W'(probe_reg) + CNT_W'(1));
    assign cmp_hi    = gt ? CNT_W'(probe_reg) : hi_reg;
    assign cmp_empty = (cmp_low >= cmp_hi);
    assign cmp_sum   = (CNT_W+1)'(cmp_low) + (CNT_W+1)'(cmp_hi) - (CNT_W+1)'(1);
    assign cmp_probe = ADDR_W'(cmp_sum >> 1);

    always_comb
    begin
        state_next       = state_reg;
        low_next         = low_reg;
        hi_next          = hi_reg;
        probe_next       = probe_reg;
        key_next         = key_reg;
        done_next        = 1'b0;
        found_next       = found_reg;
        found_index_next = found_index_reg;
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_addr         = ADDR_W'(first_probe);
        mem_wdata        = entry_value;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACTION_WRITE)
                    begin
                        mem_we   = wr_in_range;
                        mem_addr = ADDR_W'(entry_index);
                    end
                    else if (n_sat == '0)
                    begin
                        done_next        = 1'b1;
                        found_next       = 1'b0;
                        found_index_next = '0;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        low_next   = '0;
                        hi_next    = n_sat;
                        probe_next = ADDR_W'(first_probe);
                        key_next   = $signed(search_key);
                        state_next = ST_CMP;
                    end
                end
            end
            ST_CMP:
            begin
                mem_addr = cmp_probe;
                if (eq)
                begin
                    done_next        = 1'b1;
                    found_next       = 1'b1;
                    found_index_next = INDEX_W'(probe_reg);
                    state_next       = ST_IDLE;
                end
                else if (cmp_empty)
                begin
                    done_next        = 1'b1;
                    found_next       = 1'b0;
                    found_index_next = '0;
                    state_next       = ST_IDLE;
                end
                else
                begin
                    mem_re     = 1'b1;
                    low_next   = cmp_low;
                    hi_next    = cmp_hi;
                    probe_next = cmp_probe;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        low_reg         <= low_next;
        hi_reg          <= hi_next;
        probe_reg       <= probe_next;
        key_reg         <= key_next;
        found_reg       <= found_next;
        found_index_reg <= found_index_next;
    end

    assign result.done        = done_reg;
    assign result.found       = found_reg;
    assign result.found_index = found_index_reg;

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("table written and read in the same cycle");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == ST_CMP || (accept && action == ACTION_SEARCH)))
        else $error("result strobe without a finished search");

    a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (low_reg < hi_reg && CNT_W'(probe_reg) < hi_reg))
        else $error("probe outside the open search range");

    a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !found_reg) |-> (found_index_reg == '0))
        else $error("miss reported with non-zero index");

endmodule

// File: src/sorted_table_binary_search.sv
// Write transaction: busy stays low; the entry is readable on the next cycle.
// Search transaction: done strobes after the last of its k probes, k <= log2(n)+1,
// one probe per cycle through the registered read port of the single-ported table RAM.
// Empty table: done strobes in the cycle after acceptance. A new transaction may start in the
// cycle that done strobes. The receiver cannot stall; each result is shown for one cycle.
// Reset clears entry_count and control state; table contents are undefined until written.
module sorted_table_binary_search
    import sts_pkg::*;
#(
    parameter int TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               action,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [DATA_W-1:0]  entry_value,
    input  logic [DATA_W-1:0]  search_key,
    output logic               done,
    output logic               found,
    output logic [INDEX_W-1:0] found_index,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [COUNT_W-1:0] entry_count_reg;
    logic               mem_we;
    logic               mem_re;
    logic [ADDR_W-1:0]  mem_addr;
    logic [DATA_W-1:0]  mem_wdata;
    logic [DATA_W-1:0]  mem_rdata;
    result_t            result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    sts_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .entry_count (entry_count_reg),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .mem_rdata   (mem_rdata),
        .result      (result)
    );

    sts_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    assign done        = result.done;
    assign found       = result.found;
    assign found_index = result.found_index;

endmodule

// File: dv/search_checker.sv
module search_checker
    import sts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic               action,
    input  logic [INDEX_W-1:0] entry_index,
    input  logic [DATA_W-1:0]  entry_value,
    input  logic [DATA_W-1:0]  search_key,
    input  logic               done,
    input  logic               found,
    input  logic [INDEX_W-1:0] found_index,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [COUNT_W-1:0] cfg_data,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 256;

    typedef struct packed {
        logic               hit;
        logic [INDEX_W-1:0] index;
    } lookup_t;

    logic signed [DATA_W-1:0] entries [DEPTH];
    logic [COUNT_W-1:0]       active_count = '0;
    lookup_t                  lookups_due [$];
    lookup_t                  oldest;

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic lookup_t search_table(logic signed [DATA_W-1:0] key);
        int      span;
        int      lo;
        int      hi;
        int      mid;
        lookup_t r;
        r    = '0;
        span = (active_count > DEPTH) ? DEPTH : int'(active_count);
        lo   = 0;
        hi   = span - 1;
        while (lo <= hi && !r.hit)
        begin
            mid = (lo + hi) / 2;
            if (entries[mid] == key)
            begin
                r.hit   = 1'b1;
                r.index = mid[INDEX_W-1:0];
            end
            else if (entries[mid] > key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (lookups_due.size() == 0)
                begin
                    $error("result with no search transaction outstanding");
                    mismatches++;
                end
                else
                begin
                    oldest = lookups_due.pop_front();
                    if (found !== oldest.hit)
                    begin
                        $error("found: expected %0d, got %0d", oldest.hit, found);
                        mismatches++;
                    end
                    if (found_index !== oldest.index)
                    begin
                        $error("found_index: expected %0d, got %0d", oldest.index, found_index);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                active_count = cfg_data;
            if (start && !busy)
            begin
                if (action == ACTION_WRITE)
                    entries[entry_index] = entry_value;
                else
                    lookups_due.push_back(search_table(search_key));
            end
            outstanding = lookups_due.size();
        end
    end

endmodule

// File: dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RUN_ITEMS   = 550;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               start       = 1'b0;
    logic               action      = ACTION_WRITE;
    logic [INDEX_W-1:0] entry_index = '0;
    logic [DATA_W-1:0]  entry_value = '0;
    logic [DATA_W-1:0]  search_key  = '0;
    logic               cfg_valid   = 1'b0;
    logic [COUNT_W-1:0] cfg_data    = '0;
    logic               busy;
    logic               done;
    logic               found;
    logic [INDEX_W-1:0] found_index;
    logic               cfg_ready;
    int                 mismatches;
    int                 outstanding;

    int                       cycles     = 0;
    int                       items_sent = 0;
    int                       burst_left = 0;
    int                       live_count = 0;
    logic signed [DATA_W-1:0] mirror [256];

    sorted_table_binary_search uut (.*);

    search_checker u_checker (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] key);
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        start       <= 1'b1;
        action      <= act;
        entry_index <= idx;
        entry_value <= val;
        search_key  <= key;
        do
            @(posedge clk);
        while (busy);
        burst_left--;
        items_sent++;
        if (act == ACTION_WRITE)
            mirror[idx] = val;
        @(negedge clk);
    endtask

    task automatic write_entry(input logic [INDEX_W-1:0] idx, input logic [DATA_W-1:0] val);
        send_item(ACTION_WRITE, idx, val, $urandom());
    endtask

    task automatic look_up(input logic [DATA_W-1:0] key);
        send_item(ACTION_SEARCH, INDEX_W'($urandom()), $urandom(), key);
    endtask

    // hold off until every outstanding search has reported
    task automatic quiesce();
        start <= 1'b0;
        burst_left = 0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_count(input int n);
        cfg_valid <= 1'b1;
        cfg_data  <= n[COUNT_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cfg_data  <= COUNT_W'($urandom());
        live_count = n;
    endtask

    task automatic fill_sorted(input int n);
        longint stride;
        longint v;
        int     i;
        if ($urandom_range(0, 2) == 0)
        begin
            stride = 3;
            v      = longint'($signed($urandom()));
        end
        else
        begin
            stride = 64'd4294967295 / (n + 1);
            v      = -64'sd2147483648 + $urandom_range(0, 32'(stride));
        end
        for (i = 0; i < n; i++)
        begin
            if (v > 64'sd2147483647)
                v = 64'sd2147483647;
            write_entry(i[INDEX_W-1:0], v[DATA_W-1:0]);
            v += $urandom_range(0, 32'(stride));
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_key();
        int span;
        int r;
        int i;
        span = (live_count > 256) ? 256 : live_count;
        r    = $urandom_range(0, 9);
        if (span == 0 || r == 9)
            return $urandom();
        i = $urandom_range(0, span - 1);
        if (r < 6)
            return mirror[i];
        if (r == 6)
            return mirror[i] + 1;
        if (r == 7)
            return mirror[i] - 1;
        return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    initial
    begin
        int phase;
        int n;
        int searches;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table
        look_up(32'h0000_0000);
        look_up(32'hFFFF_FFFF);

        quiesce();
        set_count(4);
        write_entry(8'd0, 32'h8000_0000);
        write_entry(8'd1, 32'hFFFF_FFFF);
        write_entry(8'd2, 32'h0000_0000);
        write_entry(8'd3, 32'h7FFF_FFFF);
        for (int k = 0; k < 4; k++)
            look_up(mirror[k]);
        look_up(32'hFFFF_FFFB);
        look_up(32'h0000_0001);
        look_up(32'h7FFF_FFFE);

        quiesce();
        set_count(1);
        look_up(32'h8000_0000);
        look_up(32'h0000_0000);

        // unsorted contents
        quiesce();
        set_count(4);
        write_entry(8'd1, 32'h7FFF_FFFF);
        look_up(32'h0000_0000);
        look_up(32'hFFFF_FFFF);

        for (phase = 0; items_sent < RUN_ITEMS; phase++)
        begin
            quiesce();
            if (phase == 3)
                n = 256;
            else if (phase == 4)
                n = 511;
            else if ($urandom_range(0, 7) == 0)
                n = 0;
            else
                n = $urandom_range(1, 20);
            set_count(n);
            if (n > 0 && n <= 256)
                fill_sorted(n);
            searches = (n >= 256) ? 24 : $urandom_range(3, 12);
            repeat (searches)
            begin
                if ($urandom_range(0, 11) == 0)
                    write_entry(INDEX_W'($urandom()), $urandom());
                look_up(pick_key());
            end
        end

        start <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
